// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on i_clk with reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/lbhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbhc_pkg
// Types, field positions, error codes and expected bytes of the header check.
// ----------------------------------------------------------------------------
package lbhc_pkg;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MAGIC     = 3'd1;
    localparam logic [2:0] ERR_VERSION   = 3'd2;
    localparam logic [2:0] ERR_DATA      = 3'd3;
    localparam logic [2:0] ERR_SIZE      = 3'd4;
    localparam logic [2:0] ERR_CHECK_INT = 3'd5;
    localparam logic [2:0] ERR_CHECK_NUM = 3'd6;

    // Byte positions inside the header
    localparam logic [5:0] POS_MAGIC_END = 6'd4;
    localparam logic [5:0] POS_VERSION   = 6'd4;
    localparam logic [5:0] POS_FORMAT    = 6'd5;
    localparam logic [5:0] POS_DATA_END  = 6'd12;
    localparam logic [5:0] POS_SIZE_END  = 6'd17;
    localparam logic [5:0] MIN_HDR_LEN   = 6'd18;

    localparam logic [7:0]  VERSION_BYTE = 8'h53;
    localparam logic [63:0] CHECK_INT    = 64'h0000_0000_0000_5678;
    localparam logic [63:0] CHECK_NUM    = 64'h4077_2800_0000_0000;  // 370.5
    localparam logic [3:0]  NUM_SIZE     = 4'd8;

    typedef logic [3:0] t_width;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } t_item;

    typedef struct packed {
        logic       valid_res;
        logic [2:0] error_code;
        logic       format_warning;
        logic [5:0] header_length;
        t_width     int_width;
        t_width     size_width;
        t_width     instruction_width;
        t_width     lua_int_width;
        t_width     lua_number_width;
        logic       little_endian;
        logic [7:0] upvalue_count;
    } t_result;

    // Expected magic and data bytes; version and format slots are unused
    function automatic logic [7:0] expected_byte(input logic [5:0] pos);
        logic [7:0] e;
        case (pos)
            6'd0:    e = 8'h1B;
            6'd1:    e = 8'h4C;
            6'd2:    e = 8'h75;
            6'd3:    e = 8'h61;
            6'd6:    e = 8'h19;
            6'd7:    e = 8'h93;
            6'd8:    e = 8'h0D;
            6'd9:    e = 8'h0A;
            6'd10:   e = 8'h1A;
            6'd11:   e = 8'h0A;
            default: e = 8'h00;
        endcase
        return e;
    endfunction

    // Full 8-byte swap
    function automatic logic [63:0] byteswap64(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = v[8*(7-i) +: 8];
        end
        return r;
    endfunction

endpackage

// File: design/lbhc_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbhc_in_stage
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module lbhc_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lbhc_pkg::t_item i_item,
    input  logic          i_advance,
    output logic          o_valid,
    output lbhc_pkg::t_item o_item
);
    import lbhc_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Free when empty or when the held byte moves on this cycle
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// File: design/lbhc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbhc_parser
// Header state and the per-byte check; produces at most one result per byte.
// ----------------------------------------------------------------------------
module lbhc_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  lbhc_pkg::t_item   i_item,
    output logic              o_emit,
    output lbhc_pkg::t_result o_res
);
    import lbhc_pkg::*;

    logic [5:0]  r_pos;
    logic        r_active;
    t_width      r_sizes [5];
    logic [63:0] r_acc;
    logic        r_endian;
    logic        r_warn;

    logic [5:0]  n_pos;
    logic        n_active;
    t_width      n_sizes [5];
    logic [63:0] n_acc;
    logic        n_endian;
    logic        n_warn;

    // State as seen by this byte (after a possible restart)
    logic [5:0]  cur_pos;
    logic        cur_active;
    t_width      cur_sizes [5];
    logic [63:0] cur_acc;
    logic        cur_endian;
    logic        cur_warn;

    logic [7:0]  b;
    logic [63:0] acc_shift;
    logic [63:0] swapped;
    logic [63:0] rev_li;
    logic [63:0] num_val;
    logic [5:0]  ci_end;
    logic [5:0]  cn_end;
    logic [2:0]  size_idx;
    logic        fin;
    logic [2:0]  err;
    logic [5:0]  len;
    logic [7:0]  upv;

    assign b = i_item.data_byte;

    // Restart view of the state
    always_comb begin
        if (i_item.start_req) begin
            cur_active = 1'b1;
            cur_pos    = '0;
            cur_acc    = '0;
            cur_endian = 1'b0;
            cur_warn   = 1'b0;
            for (int i = 0; i < 5; i++) begin
                cur_sizes[i] = '0;
            end
        end else begin
            cur_active = r_active;
            cur_pos    = r_pos;
            cur_acc    = r_acc;
            cur_endian = r_endian;
            cur_warn   = r_warn;
            cur_sizes  = r_sizes;
        end
    end

    // Field assembly helpers
    assign acc_shift = {cur_acc[55:0], b};
    assign swapped   = byteswap64(acc_shift);
    assign ci_end    = POS_SIZE_END + {2'b00, cur_sizes[3]};
    assign cn_end    = ci_end + {2'b00, cur_sizes[4]};
    assign size_idx  = cur_pos[2:0] - 3'd4;
    assign num_val   = cur_endian ? swapped : acc_shift;

    // Little-endian reading of the check integer over its declared width
    always_comb begin
        case (cur_sizes[3])
            4'd2:    rev_li = {48'h0, swapped[63:48]};
            4'd4:    rev_li = {32'h0, swapped[63:32]};
            default: rev_li = swapped;
        endcase
    end

    // Per-byte check
    always_comb begin
        n_active = cur_active;
        n_pos    = cur_pos;
        n_sizes  = cur_sizes;
        n_acc    = cur_acc;
        n_endian = cur_endian;
        n_warn   = cur_warn;
        fin      = 1'b0;
        err      = ERR_NONE;
        len      = '0;
        upv      = '0;
        if (cur_active) begin
            n_pos = cur_pos + 6'd1;
            if (cur_pos < POS_MAGIC_END) begin
                if (b != expected_byte(cur_pos)) begin
                    fin = 1'b1;
                    err = ERR_MAGIC;
                end
            end else if (cur_pos == POS_VERSION) begin
                if (b != VERSION_BYTE) begin
                    fin = 1'b1;
                    err = ERR_VERSION;
                end
            end else if (cur_pos == POS_FORMAT) begin
                n_warn = (b != 8'h00);
            end else if (cur_pos < POS_DATA_END) begin
                if (b != expected_byte(cur_pos)) begin
                    fin = 1'b1;
                    err = ERR_DATA;
                end
            end else if (cur_pos < POS_SIZE_END) begin
                if (b == 8'd2 || b == 8'd4 || b == 8'd8) begin
                    n_sizes[size_idx] = b[3:0];
                    n_acc             = '0;
                end else begin
                    fin = 1'b1;
                    err = ERR_SIZE;
                end
            end else if (cur_pos < ci_end) begin
                n_acc = acc_shift;
                if (cur_pos == ci_end - 6'd1) begin
                    n_acc = '0;
                    if (acc_shift != CHECK_INT) begin
                        if (rev_li == CHECK_INT) begin
                            n_endian = 1'b1;
                        end else begin
                            fin = 1'b1;
                            err = ERR_CHECK_INT;
                        end
                    end
                end
            end else if (cur_pos < cn_end) begin
                n_acc = acc_shift;
                if (cur_pos == cn_end - 6'd1) begin
                    n_acc = '0;
                    if (cur_sizes[4] != NUM_SIZE || num_val != CHECK_NUM) begin
                        fin = 1'b1;
                        err = ERR_CHECK_NUM;
                    end
                end
            end else begin
                // Upvalues byte closes a good header
                fin = 1'b1;
                len = cur_pos + 6'd1;
                upv = b;
            end
            if (fin) begin
                n_active = 1'b0;
            end
        end
    end

    // Result
    assign o_emit = fin;
    always_comb begin
        o_res.valid_res         = (err == ERR_NONE);
        o_res.error_code        = err;
        o_res.format_warning    = cur_warn;
        o_res.header_length     = len;
        o_res.int_width         = cur_sizes[0];
        o_res.size_width        = cur_sizes[1];
        o_res.instruction_width = cur_sizes[2];
        o_res.lua_int_width     = cur_sizes[3];
        o_res.lua_number_width  = cur_sizes[4];
        o_res.little_endian     = cur_endian;
        o_res.upvalue_count     = upv;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
            r_acc    <= '0;
            r_endian <= 1'b0;
            r_warn   <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                r_sizes[i] <= '0;
            end
        end else if (i_en) begin
            r_active <= n_active;
            r_pos    <= n_pos;
            r_acc    <= n_acc;
            r_endian <= n_endian;
            r_warn   <= n_warn;
            r_sizes  <= n_sizes;
        end
    end

endmodule

// File: design/lua53_bytecode_header_check.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// lua53_bytecode_header_check
// Streaming checker for a Lua 5.3 bytecode header, one byte per transfer.
// ----------------------------------------------------------------------------
// Feed the header one byte per transfer, with start_req set on its first
// byte; start_req also abandons any header in progress. The block takes one
// byte every cycle and answers, through its input and result registers, after
// the byte that decides the header: one result on the first failing byte, or
// after the upvalues byte when every check passes, and nothing for the other
// bytes or for bytes that arrive while no header is open. Throughput is one
// byte per cycle, set by the input register feeding the single-pass check into
// the result register; it drops only while a result waits on i_out_ready.
module lua53_bytecode_header_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Byte stream
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_start_req,
    // Result
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_valid_res,
    output logic [2:0] o_error_code,
    output logic       o_format_warning,
    output logic [5:0] o_header_length,
    output logic [3:0] o_int_width,
    output logic [3:0] o_size_width,
    output logic [3:0] o_instruction_width,
    output logic [3:0] o_lua_int_width,
    output logic [3:0] o_lua_number_width,
    output logic       o_little_endian,
    output logic [7:0] o_upvalue_count
);
    import lbhc_pkg::*;

    t_item   in_item;
    t_item   st_item;
    logic    st_valid;
    logic    advance;
    logic    emit;
    t_result res;

    logic    r_out_valid;
    t_result r_out;

    assign in_item.data_byte = i_data_byte;
    assign in_item.start_req = i_start_req;

    // Held byte moves on once the result slot is free or draining
    assign advance = st_valid && (!r_out_valid || i_out_ready);

    lbhc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (st_valid),
        .o_item    (st_item)
    );

    lbhc_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (st_item),
        .o_emit  (emit),
        .o_res   (res)
    );

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_valid_res         = r_out.valid_res;
    assign o_error_code        = r_out.error_code;
    assign o_format_warning    = r_out.format_warning;
    assign o_header_length     = r_out.header_length;
    assign o_int_width         = r_out.int_width;
    assign o_size_width        = r_out.size_width;
    assign o_instruction_width = r_out.instruction_width;
    assign o_lua_int_width     = r_out.lua_int_width;
    assign o_lua_number_width  = r_out.lua_number_width;
    assign o_little_endian     = r_out.little_endian;
    assign o_upvalue_count     = r_out.upvalue_count;

    // Checks
    `ASSERT_IMP(a_pass_shape, o_out_valid && o_valid_res,
        o_error_code == ERR_NONE && o_header_length >= MIN_HDR_LEN,
        "passing result without length or with an error code")
    `ASSERT_IMP(a_fail_shape, o_out_valid && !o_valid_res,
        o_header_length == 6'd0 && o_upvalue_count == 8'd0,
        "failing result carries length or upvalues")
    `ASSERT_IMP(a_le_needs_int, o_out_valid && o_little_endian,
        o_lua_int_width != 4'd0 && o_error_code != ERR_CHECK_INT,
        "little-endian flag without a matched check integer")
    `ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid,
        "pending result dropped")

endmodule

// File: sim/lbhc_result_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbhc_result_monitor
// Watches both channels of the header checker, predicts each verdict from the
// accepted byte stream and compares every delivered result field by field.
// ----------------------------------------------------------------------------
module lbhc_result_monitor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Byte stream
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_start_req,
    // Result
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_valid_res,
    input  logic [2:0] i_error_code,
    input  logic       i_format_warning,
    input  logic [5:0] i_header_length,
    input  logic [3:0] i_int_width,
    input  logic [3:0] i_size_width,
    input  logic [3:0] i_instruction_width,
    input  logic [3:0] i_lua_int_width,
    input  logic [3:0] i_lua_number_width,
    input  logic       i_little_endian,
    input  logic [7:0] i_upvalue_count,
    // Status to the testbench top
    output int         o_fail_count,
    output int         o_pending
);
    import lbhc_pkg::*;

    localparam logic [7:0] SIG_BYTES  [4] = '{8'h1B, 8'h4C, 8'h75, 8'h61};
    localparam logic [7:0] TAIL_BYTES [6] = '{8'h19, 8'h93, 8'h0D, 8'h0A, 8'h1A, 8'h0A};

    // Predictor state
    logic [5:0]  hp_pos;
    bit          hp_open;
    t_width      hp_size [5];
    logic [63:0] hp_acc;
    bit          hp_le;
    bit          hp_warn;

    t_result     pending_verdicts [$];
    int          result_idx;

    // Start a fresh header
    function automatic void clear_header();
        hp_pos  = '0;
        hp_acc  = '0;
        hp_le   = 1'b0;
        hp_warn = 1'b0;
        for (int i = 0; i < 5; i++) begin
            hp_size[i] = '0;
        end
    endfunction

    // Reverse the low n bytes of v
    function automatic logic [63:0] flip_bytes(input logic [63:0] v, input int n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < n; i++) begin
            r = {r[55:0], v[8*i +: 8]};
        end
        return r;
    endfunction

    // Advance the header check by one byte; returns 1 when a verdict is due
    function automatic bit advance_header(input logic [7:0] b, input logic s,
                                          output t_result r);
        logic [5:0]  p;
        int          li, ln, ci_end, cn_end;
        logic [2:0]  err;
        bit          done;
        logic [63:0] v;
        r    = '0;
        err  = ERR_NONE;
        done = 1'b0;
        if (s) begin
            clear_header();
            hp_open = 1'b1;
        end
        if (!hp_open) begin
            return 1'b0;
        end
        p      = hp_pos;
        hp_pos = p + 6'd1;
        li     = hp_size[3];
        ln     = hp_size[4];
        ci_end = POS_SIZE_END + li;
        cn_end = ci_end + ln;

        if (p < POS_MAGIC_END) begin
            if (b != SIG_BYTES[p]) begin
                done = 1'b1;
                err  = ERR_MAGIC;
            end
        end else if (p == POS_VERSION) begin
            if (b != VERSION_BYTE) begin
                done = 1'b1;
                err  = ERR_VERSION;
            end
        end else if (p == POS_FORMAT) begin
            hp_warn = (b != 8'h00);
        end else if (p < POS_DATA_END) begin
            if (b != TAIL_BYTES[p - POS_FORMAT - 1]) begin
                done = 1'b1;
                err  = ERR_DATA;
            end
        end else if (p < POS_SIZE_END) begin
            // Size bytes: only 2, 4 or 8 allowed
            if (b == 8'd2 || b == 8'd4 || b == 8'd8) begin
                hp_size[p - POS_DATA_END] = b[3:0];
                hp_acc = '0;
            end else begin
                done = 1'b1;
                err  = ERR_SIZE;
            end
        end else if (p < ci_end) begin
            // Check integer, judged on its last byte
            hp_acc = {hp_acc[55:0], b};
            if (p == ci_end - 1) begin
                v      = hp_acc;
                hp_acc = '0;
                if (v != CHECK_INT) begin
                    if (flip_bytes(v, li) == CHECK_INT) begin
                        hp_le = 1'b1;
                    end else begin
                        done = 1'b1;
                        err  = ERR_CHECK_INT;
                    end
                end
            end
        end else if (p < cn_end) begin
            // Check number, read in the kept byte order
            hp_acc = {hp_acc[55:0], b};
            if (p == cn_end - 1) begin
                v      = hp_le ? flip_bytes(hp_acc, ln) : hp_acc;
                hp_acc = '0;
                if (ln != NUM_SIZE || v != CHECK_NUM) begin
                    done = 1'b1;
                    err  = ERR_CHECK_NUM;
                end
            end
        end else begin
            // Upvalues byte closes a good header
            done = 1'b1;
        end

        if (done) begin
            r.valid_res         = (err == ERR_NONE);
            r.error_code        = err;
            r.format_warning    = hp_warn;
            r.header_length     = (err == ERR_NONE) ? p + 6'd1 : 6'd0;
            r.int_width         = hp_size[0];
            r.size_width        = hp_size[1];
            r.instruction_width = hp_size[2];
            r.lua_int_width     = hp_size[3];
            r.lua_number_width  = hp_size[4];
            r.little_endian     = hp_le;
            r.upvalue_count     = (err == ERR_NONE) ? b : 8'h00;
            hp_open             = 1'b0;
        end
        return done;
    endfunction

    // One field compare; only the first ten are printed
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("result %0d: %s expected %0h got %0h",
                         result_idx, name, want, got);
            end
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        t_result pred;
        if (!i_rst_n) begin
            clear_header();
            hp_open = 1'b0;
            pending_verdicts.delete();
            o_pending  = 0;
            result_idx = 0;
        end else begin
            // Result transfer
            if (i_out_valid && i_out_ready) begin
                seen = '{i_valid_res, i_error_code, i_format_warning, i_header_length,
                         i_int_width, i_size_width, i_instruction_width,
                         i_lua_int_width, i_lua_number_width, i_little_endian,
                         i_upvalue_count};
                if (pending_verdicts.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("result %0d: none expected, got error_code %0d",
                                 result_idx, seen.error_code);
                    end
                end else begin
                    want = pending_verdicts.pop_front();
                    check_field("valid_res", want.valid_res, seen.valid_res);
                    check_field("error_code", want.error_code, seen.error_code);
                    check_field("format_warning", want.format_warning,
                                seen.format_warning);
                    check_field("header_length", want.header_length,
                                seen.header_length);
                    check_field("int_width", want.int_width, seen.int_width);
                    check_field("size_width", want.size_width, seen.size_width);
                    check_field("instruction_width", want.instruction_width,
                                seen.instruction_width);
                    check_field("lua_int_width", want.lua_int_width,
                                seen.lua_int_width);
                    check_field("lua_number_width", want.lua_number_width,
                                seen.lua_number_width);
                    check_field("little_endian", want.little_endian,
                                seen.little_endian);
                    check_field("upvalue_count", want.upvalue_count,
                                seen.upvalue_count);
                end
                result_idx++;
            end
            // Byte transfer
            if (i_in_valid && i_in_ready) begin
                if (advance_header(i_data_byte, i_start_req, pred)) begin
                    pending_verdicts.push_back(pred);
                end
            end
            o_pending = pending_verdicts.size();
        end
    end

endmodule

// File: sim/lua53_bytecode_header_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lua53_bytecode_header_check_tb
// Drives headers, broken headers and noise into the header checker with
// random gaps on both sides; a monitor predicts and checks every verdict.
// ----------------------------------------------------------------------------
module lua53_bytecode_header_check_tb;
    import lbhc_pkg::*;

    localparam int         BYTE_TARGET    = 1050;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         DRAIN_CYCLES   = 10;
    localparam logic [7:0] SIG_BYTES  [4] = '{8'h1B, 8'h4C, 8'h75, 8'h61};
    localparam logic [7:0] TAIL_BYTES [6] = '{8'h19, 8'h93, 8'h0D, 8'h0A, 8'h1A, 8'h0A};

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_start_req = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_valid_res;
    logic [2:0] o_error_code;
    logic       o_format_warning;
    logic [5:0] o_header_length;
    logic [3:0] o_int_width;
    logic [3:0] o_size_width;
    logic [3:0] o_instruction_width;
    logic [3:0] o_lua_int_width;
    logic [3:0] o_lua_number_width;
    logic       o_little_endian;
    logic [7:0] o_upvalue_count;

    int         fail_count;
    int         pending;
    int         bytes_sent;
    int         idle_cycles;
    bit         in_calm;
    bit         out_calm;
    logic [7:0] hdr_bytes [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    lua53_bytecode_header_check uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_data_byte         (i_data_byte),
        .i_start_req         (i_start_req),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_valid_res         (o_valid_res),
        .o_error_code        (o_error_code),
        .o_format_warning    (o_format_warning),
        .o_header_length     (o_header_length),
        .o_int_width         (o_int_width),
        .o_size_width        (o_size_width),
        .o_instruction_width (o_instruction_width),
        .o_lua_int_width     (o_lua_int_width),
        .o_lua_number_width  (o_lua_number_width),
        .o_little_endian     (o_little_endian),
        .o_upvalue_count     (o_upvalue_count)
    );

    lbhc_result_monitor mon (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_data_byte         (i_data_byte),
        .i_start_req         (i_start_req),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_valid_res         (o_valid_res),
        .i_error_code        (o_error_code),
        .i_format_warning    (o_format_warning),
        .i_header_length     (o_header_length),
        .i_int_width         (o_int_width),
        .i_size_width        (o_size_width),
        .i_instruction_width (o_instruction_width),
        .i_lua_int_width     (o_lua_int_width),
        .i_lua_number_width  (o_lua_number_width),
        .i_little_endian     (o_little_endian),
        .i_upvalue_count     (o_upvalue_count),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    // One byte transfer, with a random gap in front unless in a calm stretch
    task automatic send_byte(input logic [7:0] b, input logic s);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_start_req <= s;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    // Header: random sizes, order, format, upvalues; well-formed if sz[4]==8
    task automatic fill_header();
        int sz [5];
        bit le;
        int i;
        hdr_bytes.delete();
        for (i = 0; i < 4; i++) hdr_bytes.push_back(SIG_BYTES[i]);
        hdr_bytes.push_back(VERSION_BYTE);
        hdr_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
        for (i = 0; i < 6; i++) hdr_bytes.push_back(TAIL_BYTES[i]);
        for (i = 0; i < 5; i++) begin
            sz[i] = 2 << $urandom_range(0, 2);
            hdr_bytes.push_back(8'(sz[i]));
        end
        // Number size is mostly 8 so that full headers can pass
        if ($urandom_range(0, 3) != 0) begin
            sz[4]         = 8;
            hdr_bytes[16] = 8'd8;
        end
        le = $urandom_range(0, 1);
        for (i = 0; i < sz[3]; i++) begin
            hdr_bytes.push_back(le ? CHECK_INT[8*i +: 8] : CHECK_INT[8*(sz[3]-1-i) +: 8]);
        end
        for (i = 0; i < sz[4]; i++) begin
            if (sz[4] == 8) begin
                hdr_bytes.push_back(le ? CHECK_NUM[8*i +: 8] : CHECK_NUM[8*(7-i) +: 8]);
            end else begin
                hdr_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        hdr_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Result side: random stall per result, with calm stretches
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
            stall = out_calm ? 0 : $urandom_range(0, 4);
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                do @(posedge i_clk); while (!o_out_valid);
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("lua53_bytecode_header_check_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        int kind;
        int cut;
        int restart_at;
        int pos;
        int n;
        int i;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle, magic errors, restart, version and data errors
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h1B, 1'b1);
        send_byte(8'h4C, 1'b0);
        send_byte(8'h75, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h1B, 1'b1);
        send_byte(8'h4C, 1'b0);
        send_byte(8'h1B, 1'b1);
        send_byte(8'h4C, 1'b0);
        send_byte(8'h75, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h52, 1'b0);
        for (i = 0; i < 4; i++) send_byte(SIG_BYTES[i], i == 0);
        send_byte(VERSION_BYTE, 1'b0);
        send_byte(8'h07, 1'b0);
        for (i = 0; i < 5; i++) send_byte(TAIL_BYTES[i], 1'b0);
        send_byte(8'h0B, 1'b0);

        // Random: mostly well-formed headers, some corrupted, cut or noise
        while (bytes_sent < BYTE_TARGET) begin
            in_calm = ($urandom_range(0, 3) == 0);
            kind    = $urandom_range(0, 99);
            if (kind < 80) begin
                fill_header();
                cut        = hdr_bytes.size();
                restart_at = -1;
                if (kind >= 50 && kind < 75) begin
                    pos = ($urandom_range(0, 2) == 0) ? $urandom_range(12, 16)
                                                     : $urandom_range(0, cut - 1);
                    hdr_bytes[pos] = hdr_bytes[pos] ^ 8'($urandom_range(1, 255));
                end else if (kind >= 75) begin
                    // Abandoned: the next start cuts it off
                    cut = $urandom_range(1, cut - 1);
                end
                if ($urandom_range(0, 9) == 0) restart_at = $urandom_range(1, cut);
                for (i = 0; i < cut; i++) send_byte(hdr_bytes[i], i == 0 || i == restart_at);
            end else if (kind < 95) begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) begin
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
            end else begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("lua53_bytecode_header_check_tb OK");
        end else begin
            $display("lua53_bytecode_header_check_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/lbhc_pkg.sv
design/lbhc_in_stage.sv
design/lbhc_parser.sv
design/lua53_bytecode_header_check.sv
sim/lbhc_result_monitor.sv
sim/lua53_bytecode_header_check_tb.sv
